/* rtl/core/brc_table_pkg.sv */
// shared types and codes for the byte range coverage table
package brc_table_pkg;

  localparam int BOUND_W = 48;
  localparam int LEN_W   = 32;
  localparam int TOTAL_W = 49;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_QUERY  = 2'd1,
    K_COVER  = 2'd2,
    K_CLEAR  = 2'd3
  } kind_t;

  typedef struct packed {
    logic               status;
    logic [BOUND_W-1:0] hole_start;
    logic [LEN_W-1:0]   hole_length;
    logic               last;
  } res_t;

endpackage

/* rtl/core/brc_table_mem.sv */
// two-bank range table storage, one write and one registered read port
module brc_table_mem import brc_table_pkg::*; #(
  parameter int AW = 5
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [BOUND_W-1:0] wbegin,
  input  logic [BOUND_W-1:0] wend,
  input  logic [AW-1:0]      raddr,
  output logic [BOUND_W-1:0] rbegin,
  output logic [BOUND_W-1:0] rend
);

  logic [BOUND_W-1:0] mem_b [2**AW];
  logic [BOUND_W-1:0] mem_e [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_b[waddr] <= wbegin;
      mem_e[waddr] <= wend;
    end
    rbegin <= mem_b[raddr];
    rend   <= mem_e[raddr];
  end

endmodule

/* rtl/core/brc_table_engine.sv */
// sequencer that scans the range table one entry per step
module brc_table_engine import brc_table_pkg::*; #(
  parameter int MAX_RANGES  = 16,
  parameter int OFFSET_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         kind,
  input  logic [46:0]        offset,
  input  logic [LEN_W-1:0]   length,
  output logic               busy,
  output logic               res_valid,
  output res_t               res,
  output logic [TOTAL_W-1:0] total
);

  localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam logic [63:0] OFS_MASK = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_RANGES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EV   = 5'b00100,
    S_END  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;
  kind_t kind_r;
  logic [BOUND_W-1:0] off_r, wend_r, s_r, e_r, cur, pend_sub, add_r, p_start;
  logic [LEN_W-1:0] p_len, cov;
  logic [TOTAL_W-1:0] tot_work;
  logic [CW-1:0] i, n, count;
  logic bank, sub_pend, placed, merged, pv;

  logic [BOUND_W-1:0] off_in, sum_in, wend_in, rb, re, wb, wd;
  logic we, refused;
  logic [IW:0] waddr, raddr;

  assign off_in  = {1'b0, offset} & OFS_MASK[BOUND_W-1:0];
  assign sum_in  = off_in + {16'd0, length};
  assign wend_in = ({16'd0, sum_in} > OFS_MASK) ? OFS_MASK[BOUND_W-1:0] : sum_in;
  assign busy    = (state != S_IDLE);
  assign refused = !merged && (count == MAXC);
  assign raddr   = {bank, i[IW-1:0]};
  assign waddr   = {~bank, n[IW-1:0]};

  brc_table_mem #(.AW(IW + 1)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wbegin(wb), .wend(wd),
    .raddr(raddr), .rbegin(rb), .rend(re)
  );

  always_comb begin
    we = 1'b0;
    wb = rb;
    wd = re;
    if (state == S_EV && kind_r == K_INSERT) begin
      if (re < off_r) begin
        we = (n < MAXC);
      end else if (rb > wend_r) begin
        we = (n < MAXC);
        if (!placed) begin
          wb = s_r;
          wd = e_r;
        end
      end
    end else if (state == S_END && kind_r == K_INSERT && !placed) begin
      we = (n < MAXC);
      wb = s_r;
      wd = e_r;
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res = '0;
    unique case (state)
      S_IDLE: begin
        if (start && (kind == K_CLEAR || (kind == K_INSERT && !(wend_in > off_in)))) begin
          res_valid = 1'b1;
          res.last = 1'b1;
        end
      end
      S_EV: begin
        if (kind_r == K_QUERY && re > cur && rb < wend_r && rb > cur && pv) begin
          res_valid = 1'b1;
          res.hole_start = p_start;
          res.hole_length = p_len;
        end
      end
      S_END: begin
        if (kind_r == K_QUERY && cur < wend_r && pv) begin
          res_valid = 1'b1;
          res.hole_start = p_start;
          res.hole_length = p_len;
        end
      end
      S_FIN: begin
        res_valid = 1'b1;
        res.last = 1'b1;
        if (kind_r == K_INSERT) begin
          res.status = refused;
        end else if (kind_r == K_QUERY && pv) begin
          res.hole_start = p_start;
          res.hole_length = p_len;
        end else if (kind_r == K_COVER) begin
          res.hole_length = cov;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
      bank <= 1'b0;
      sub_pend <= 1'b0;
      pv <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            kind_r <= kind_t'(kind);
            off_r <= off_in;
            wend_r <= wend_in;
            s_r <= off_in;
            e_r <= wend_in;
            cur <= off_in;
            tot_work <= total;
            i <= '0;
            n <= '0;
            placed <= 1'b0;
            merged <= 1'b0;
            sub_pend <= 1'b0;
            pv <= 1'b0;
            cov <= '0;
            if (kind == K_CLEAR) begin
              count <= '0;
              total <= '0;
            end else if (!(kind == K_INSERT && !(wend_in > off_in))) begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          if (sub_pend) begin
            tot_work <= tot_work - {1'b0, pend_sub};
            sub_pend <= 1'b0;
          end
          state <= (i == count) ? S_END : S_EV;
        end
        S_EV: begin
          state <= S_RD;
          case (kind_r)
            K_INSERT: begin
              if (re < off_r) begin
                if (n < MAXC) n <= n + 1'b1;
                i <= i + 1'b1;
              end else if (rb <= wend_r) begin
                s_r <= (rb < s_r) ? rb : s_r;
                e_r <= (re > e_r) ? re : e_r;
                pend_sub <= re - rb;
                sub_pend <= 1'b1;
                merged <= 1'b1;
                i <= i + 1'b1;
              end else if (!placed) begin
                if (n < MAXC) n <= n + 1'b1;
                placed <= 1'b1;
                state <= S_EV;
              end else begin
                if (n < MAXC) n <= n + 1'b1;
                i <= i + 1'b1;
              end
            end
            K_QUERY: begin
              if (re <= cur) begin
                i <= i + 1'b1;
              end else if (rb >= wend_r) begin
                state <= S_END;
              end else begin
                if (rb > cur) begin
                  p_start <= cur;
                  p_len <= LEN_W'(rb - cur);
                  pv <= 1'b1;
                end
                cur <= re;
                i <= i + 1'b1;
              end
            end
            K_COVER: begin
              if (rb <= off_r && off_r < re) begin
                cov <= LEN_W'(((re < wend_r) ? re : wend_r) - off_r);
              end
              i <= i + 1'b1;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_END: begin
          if (kind_r == K_INSERT) begin
            if (!placed && n < MAXC) n <= n + 1'b1;
            add_r <= e_r - s_r;
            if (sub_pend) begin
              tot_work <= tot_work - {1'b0, pend_sub};
              sub_pend <= 1'b0;
            end
          end else if (kind_r == K_QUERY && cur < wend_r) begin
            p_start <= cur;
            p_len <= LEN_W'(wend_r - cur);
            pv <= 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (kind_r == K_INSERT && !refused) begin
            count <= n;
            bank <= ~bank;
            total <= tot_work + {1'b0, add_r};
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= MAXC)
    else $error("range count above table size");
  a_write_room: assert property (@(posedge clk) disable iff (rst) we |-> n < MAXC)
    else $error("table write past last entry");
  a_query_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == K_QUERY) |=> state == S_RD)
    else $error("query transfer did not start scan");
  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |-> res_valid && res.last)
    else $error("item finished without final result");

endmodule

/* rtl/core/byte_range_coverage_table_core.sv */
// top level of the byte range coverage table
// throughput: one item at a time, busy until its last result is issued
// the scan reads one table entry at a time from the registered-read table
// reset clears the range count and cached total; no clearing pass is needed
// results are strobed by valid for one cycle and cannot be stalled
module byte_range_coverage_table_core import brc_table_pkg::*; #(
  parameter int MAX_RANGES  = 16,
  parameter int OFFSET_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [46:0]        offset,
  input  logic [LEN_W-1:0]   length,
  output logic               valid,
  output logic               status,
  output logic [BOUND_W-1:0] hole_start,
  output logic [LEN_W-1:0]   hole_length,
  output logic               last,
  output logic [TOTAL_W-1:0] cached_total
);

  logic res_valid;
  res_t res;

  brc_table_engine #(.MAX_RANGES(MAX_RANGES), .OFFSET_BITS(OFFSET_BITS)) u_engine (
    .clk(clk), .rst(rst), .start(start), .kind(kind), .offset(offset),
    .length(length), .busy(busy), .res_valid(res_valid), .res(res),
    .total(cached_total)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= res_valid;
    end
    if (res_valid) begin
      status <= res.status;
      hole_start <= res.hole_start;
      hole_length <= res.hole_length;
      last <= res.last;
    end
  end

endmodule
